>>> rtl/core/swt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swt_pkg
// Shared types, character codes and helpers for the shell word tokenizer.
// ----------------------------------------------------------------------------
package swt_pkg;

  // most events one input beat can cause
  localparam int unsigned MaxEvents = 4;
  localparam int unsigned EvIdxW    = $clog2(MaxEvents);
  localparam int unsigned EvCntW    = $clog2(MaxEvents + 1);

  // default depth of the queue between front and back
  localparam int unsigned SwtQueueDepth = 4;

  // character codes
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChPipe   = 8'h7c;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0d;

  // lexer modes
  typedef enum logic [2:0] {
    LEX_PLAIN   = 3'd0,
    LEX_SQ      = 3'd1,
    LEX_DQ      = 3'd2,
    LEX_DQ_ESC  = 3'd3,
    LEX_BSL     = 3'd4,
    LEX_COMMENT = 3'd5
  } lex_mode_e;

  // result event kinds
  typedef enum logic [2:0] {
    EV_CHAR = 3'd0,
    EV_WEND = 3'd1,
    EV_PIPE = 3'd2,
    EV_OK   = 3'd3,
    EV_ERR  = 3'd4
  } event_kind_e;

  // all events caused by one input beat
  typedef struct packed {
    logic [EvCntW-1:0]                 cnt;
    event_kind_e [MaxEvents-1:0]       kind;
    logic [MaxEvents-1:0][7:0]         chr;
  } evt_rec_t;

  // blank: tab through carriage return, and space
  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  // append one event to a record
  function automatic evt_rec_t rec_push(evt_rec_t r, event_kind_e k, logic [7:0] ch);
    evt_rec_t o;
    o = r;
    o.kind[r.cnt[EvIdxW-1:0]] = k;
    o.chr[r.cnt[EvIdxW-1:0]]  = ch;
    o.cnt = r.cnt + EvCntW'(1);
    return o;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/shell_word_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shell_word_tokenizer
// Shell-style word splitting lexer with quoting, escapes, comments and pipes.
// ----------------------------------------------------------------------------
// The block takes one input beat per cycle while its queue has room (a byte, a
// valid flag in tuser and the line end in tlast) and emits one event beat per
// cycle while the output is ready: word char, word end, pipe token, line ok or
// unclosed quote error, with tlast on the final event caused by each input
// beat. A beat causes zero to four events; the front end classifies it in its
// accept cycle and the emitter drains one event per cycle from a queue of
// QueueDepth records, so sustained input rate is one beat per cycle while the
// average is at most one event per beat, and the output port sets the rate
// otherwise. The consumer drops a line that ends in an error event.
// ----------------------------------------------------------------------------
module shell_word_tokenizer import swt_pkg::*; #(
  parameter int unsigned QueueDepth = SwtQueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input stream
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  wire logic       s_axis_tuser,   // [0] byte_valid
  input  wire logic       s_axis_tlast,   // end_of_line
  // event stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] char_value
  output logic [2:0]      m_axis_tuser,   // [2:0] event_kind
  output logic            m_axis_tlast    // last_of_run
);

  logic        q_push, q_full, q_pop, q_empty;
  evt_rec_t    q_wr_rec, q_rd_rec;
  event_kind_e out_kind;

  // lexer front end
  swt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .byte_value_i  (s_axis_tdata),
    .byte_valid_i  (s_axis_tuser),
    .end_of_line_i (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_rec_o       (q_wr_rec)
  );

  // record queue
  swt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rd_rec),
    .empty_o (q_empty)
  );

  // event emitter
  swt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (q_rd_rec),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .kind_o      (out_kind),
    .chr_o       (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;

endmodule
`default_nettype wire

>>> rtl/core/swt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swt_front
// Lexer front end: holds the lexing mode and the open-word flag, and turns
// each input beat into a record of up to four events.
// ----------------------------------------------------------------------------
module swt_front import swt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       byte_valid_i,
  input  wire logic       end_of_line_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output evt_rec_t        q_rec_o
);

  lex_mode_e mode_q, mode_d, mode_mid;
  logic      word_open_q, word_open_d;
  logic      wo_plain;
  logic      bsl_special;
  logic      accept;
  evt_rec_t  rec;
  logic      wo;
  logic      do_plain;
  logic      err;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // byte after a plain backslash that is taken literally
  assign bsl_special = is_blank(byte_value_i) || (byte_value_i == ChSquote) ||
                       (byte_value_i == ChDquote) || (byte_value_i == ChPipe) ||
                       (byte_value_i == ChBslash);

  // a pending plain backslash always opens the word before plain handling
  assign wo_plain = word_open_q || (mode_q == LEX_BSL);

  // next state: mode after the byte, then after the line end
  always_comb begin
    mode_mid = mode_q;
    if (byte_valid_i) begin
      unique case (mode_q)
        LEX_SQ: begin
          if (byte_value_i == ChSquote) mode_mid = LEX_PLAIN;
        end
        LEX_DQ: begin
          if (byte_value_i == ChDquote)      mode_mid = LEX_PLAIN;
          else if (byte_value_i == ChBslash) mode_mid = LEX_DQ_ESC;
        end
        LEX_DQ_ESC: mode_mid = LEX_DQ;
        LEX_COMMENT: mode_mid = LEX_COMMENT;
        default: begin
          if ((mode_q == LEX_BSL) && bsl_special) begin
            mode_mid = LEX_PLAIN;
          end else begin
            priority if (byte_value_i == ChSquote)          mode_mid = LEX_SQ;
            else if (byte_value_i == ChDquote)              mode_mid = LEX_DQ;
            else if (byte_value_i == ChHash && !wo_plain)   mode_mid = LEX_COMMENT;
            else if (byte_value_i == ChBslash)              mode_mid = LEX_BSL;
            else                                            mode_mid = LEX_PLAIN;
          end
        end
      endcase
    end
    mode_d = end_of_line_i ? LEX_PLAIN : mode_mid;
  end

  // outputs: event record and the open-word flag it leaves
  always_comb begin
    rec      = '0;
    wo       = word_open_q;
    do_plain = 1'b0;
    err      = 1'b0;
    if (byte_valid_i) begin
      unique case (mode_q)
        LEX_SQ: begin
          if (byte_value_i != ChSquote) begin
            rec = rec_push(rec, EV_CHAR, byte_value_i);
            wo  = 1'b1;
          end
        end
        LEX_DQ: begin
          if (byte_value_i != ChDquote && byte_value_i != ChBslash) begin
            rec = rec_push(rec, EV_CHAR, byte_value_i);
            wo  = 1'b1;
          end
        end
        LEX_DQ_ESC: begin
          rec = rec_push(rec, EV_CHAR, byte_value_i);
          wo  = 1'b1;
        end
        LEX_BSL: begin
          if (bsl_special) begin
            rec = rec_push(rec, EV_CHAR, byte_value_i);
          end else begin
            rec      = rec_push(rec, EV_CHAR, ChBslash);
            do_plain = 1'b1;
          end
          wo = 1'b1;
        end
        LEX_COMMENT: ;
        default: do_plain = 1'b1;
      endcase
      // plain text handling
      if (do_plain) begin
        priority if (byte_value_i == ChSquote || byte_value_i == ChDquote) begin
        end else if (byte_value_i == ChHash && !wo) begin
        end else if (byte_value_i == ChPipe) begin
          if (wo) rec = rec_push(rec, EV_WEND, 8'h00);
          wo  = 1'b0;
          rec = rec_push(rec, EV_PIPE, 8'h00);
        end else if (is_blank(byte_value_i)) begin
          if (wo) rec = rec_push(rec, EV_WEND, 8'h00);
          wo = 1'b0;
        end else if (byte_value_i == ChBslash) begin
        end else begin
          rec = rec_push(rec, EV_CHAR, byte_value_i);
          wo  = 1'b1;
        end
      end
    end
    // line end
    if (end_of_line_i) begin
      if (mode_mid == LEX_BSL) begin
        rec = rec_push(rec, EV_CHAR, ChBslash);
        wo  = 1'b1;
      end else if (mode_mid == LEX_DQ_ESC) begin
        rec = rec_push(rec, EV_CHAR, ChBslash);
        err = 1'b1;
      end else if (mode_mid == LEX_SQ || mode_mid == LEX_DQ) begin
        err = 1'b1;
      end
      if (err) begin
        rec = rec_push(rec, EV_ERR, 8'h00);
      end else begin
        if (wo) rec = rec_push(rec, EV_WEND, 8'h00);
        rec = rec_push(rec, EV_OK, 8'h00);
      end
      wo = 1'b0;
    end
    word_open_d = wo;
  end

  assign q_rec_o  = rec;
  assign q_push_o = accept && (rec.cnt != '0);

  // lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= LEX_PLAIN;
      word_open_q <= 1'b0;
    end else if (accept) begin
      mode_q      <= mode_d;
      word_open_q <= word_open_d;
    end
  end

  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_line_i |=> mode_q == LEX_PLAIN && !word_open_q)
    else $error("state not cleared after line end");

  a_line_end_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_line_i |-> q_push_o &&
      (rec.kind[rec.cnt[EvIdxW-1:0] - EvIdxW'(1)] == EV_OK ||
       rec.kind[rec.cnt[EvIdxW-1:0] - EvIdxW'(1)] == EV_ERR))
    else $error("line end without status event");

endmodule
`default_nettype wire

>>> rtl/core/swt_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swt_fifo
// Short queue of event records between the lexer front and the emitter.
// ----------------------------------------------------------------------------
module swt_fifo import swt_pkg::*; #(
  parameter int unsigned Depth = SwtQueueDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire evt_rec_t data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output evt_rec_t      data_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  evt_rec_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");

endmodule
`default_nettype wire

>>> rtl/core/swt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swt_back
// Event emitter: walks the head record one event per cycle, while the output
// is ready, into an output register, marking the final event of each record.
// ----------------------------------------------------------------------------
module swt_back import swt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire evt_rec_t rec_i,
  input  wire logic     empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output event_kind_e   kind_o,
  output logic [7:0]    chr_o,
  output logic          last_o
);

  logic              valid_q;
  logic [EvIdxW-1:0] idx_q;
  event_kind_e       kind_q;
  logic [7:0]        chr_q;
  logic              last_q;
  logic              load;
  logic              take;
  logic              is_last;

  assign load    = !valid_q || out_ready_i;
  assign take    = load && !empty_i;
  assign is_last = ({1'b0, idx_q} + EvCntW'(1)) == rec_i.cnt;
  assign pop_o   = take && is_last;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) valid_q <= !empty_i;
      if (take) idx_q <= is_last ? '0 : idx_q + EvIdxW'(1);
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= rec_i.kind[idx_q];
      chr_q  <= rec_i.chr[idx_q];
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign chr_o       = chr_q;
  assign last_o      = last_q;

  a_idx_in_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> ({1'b0, idx_q} < rec_i.cnt))
    else $error("event index beyond head record");

endmodule
`default_nettype wire

>>> dv/swt_event_checker.sv
// ----------------------------------------------------------------------------
// swt_event_checker
// Watches both streams of the shell word tokenizer, predicts the events of
// every input beat and compares each output beat against the oldest one.
// ----------------------------------------------------------------------------
module swt_event_checker import swt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input stream
  input  wire logic       s_axis_tvalid,
  input  wire logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  wire logic       s_axis_tuser,   // [0] byte_valid
  input  wire logic       s_axis_tlast,   // end_of_line
  // event stream
  input  wire logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  input  wire logic [7:0] m_axis_tdata,   // [7:0] char_value
  input  wire logic [2:0] m_axis_tuser,   // [2:0] event_kind
  input  wire logic       m_axis_tlast,   // last_of_run
  // status for the testbench top
  output int              fail_count_o,
  output int              pending_o
);

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  chr;
    logic        last;
  } lex_event_t;

  lex_event_t expected_events[$];
  lex_event_t beat_events[$];
  lex_mode_e  mode_q;
  logic       word_open_q;

  // blank: tab through carriage return, and space
  function automatic logic blank_char(logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  // record one event of the current beat; a word char opens a word
  function automatic void add_event(event_kind_e k, logic [7:0] c);
    lex_event_t ev;
    ev.kind = k;
    ev.chr  = c;
    ev.last = 1'b0;
    beat_events.insert(beat_events.size(), ev);
    if (k == EV_CHAR) word_open_q = 1'b1;
  endfunction

  function automatic void end_word();
    if (word_open_q) begin
      add_event(EV_WEND, 8'h00);
      word_open_q = 1'b0;
    end
  endfunction

  // byte outside any quote or escape
  function automatic void plain_char(logic [7:0] c);
    mode_q = LEX_PLAIN;
    if (c == ChSquote) begin
      mode_q = LEX_SQ;
    end else if (c == ChDquote) begin
      mode_q = LEX_DQ;
    end else if (c == ChHash && !word_open_q) begin
      mode_q = LEX_COMMENT;
    end else if (c == ChPipe) begin
      end_word();
      add_event(EV_PIPE, 8'h00);
    end else if (blank_char(c)) begin
      end_word();
    end else if (c == ChBslash) begin
      mode_q = LEX_BSL;
    end else begin
      add_event(EV_CHAR, c);
    end
  endfunction

  // one valid byte in the current mode
  function automatic void lex_byte(logic [7:0] c);
    case (mode_q)
      LEX_SQ: begin
        if (c == ChSquote) mode_q = LEX_PLAIN;
        else add_event(EV_CHAR, c);
      end
      LEX_DQ: begin
        if (c == ChDquote) mode_q = LEX_PLAIN;
        else if (c == ChBslash) mode_q = LEX_DQ_ESC;
        else add_event(EV_CHAR, c);
      end
      LEX_DQ_ESC: begin
        add_event(EV_CHAR, c);
        mode_q = LEX_DQ;
      end
      LEX_BSL: begin
        if (blank_char(c) || c == ChSquote || c == ChDquote || c == ChPipe ||
            c == ChBslash) begin
          add_event(EV_CHAR, c);
          mode_q = LEX_PLAIN;
        end else begin
          add_event(EV_CHAR, ChBslash);
          plain_char(c);
        end
      end
      LEX_COMMENT: begin
      end
      default: begin
        plain_char(c);
      end
    endcase
  endfunction

  // line end: flush a pending backslash, then ok or quote error
  function automatic void close_line();
    logic quote_err;
    quote_err = 1'b0;
    case (mode_q)
      LEX_BSL: begin
        add_event(EV_CHAR, ChBslash);
      end
      LEX_DQ_ESC: begin
        add_event(EV_CHAR, ChBslash);
        quote_err = 1'b1;
      end
      LEX_SQ, LEX_DQ: begin
        quote_err = 1'b1;
      end
      default: begin
      end
    endcase
    if (quote_err) begin
      add_event(EV_ERR, 8'h00);
    end else begin
      end_word();
      add_event(EV_OK, 8'h00);
    end
    mode_q      = LEX_PLAIN;
    word_open_q = 1'b0;
  endfunction

  // predict all events of one accepted input beat
  function automatic void predict_beat(logic [7:0] c, logic valid, logic eol);
    lex_event_t ev;
    beat_events.delete();
    if (valid) lex_byte(c);
    if (eol) close_line();
    if (beat_events.size() > 0) beat_events[beat_events.size() - 1].last = 1'b1;
    foreach (beat_events[i]) begin
      ev = beat_events[i];
      expected_events.insert(expected_events.size(), ev);
    end
  endfunction

  // compare one output beat with the oldest expected event
  function automatic void check_event();
    lex_event_t want;
    if (expected_events.size() == 0) begin
      if (fail_count_o < 10)
        $display("event with none expected: kind %0d char %h last %b",
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
      fail_count_o++;
    end else begin
      want = expected_events.pop_front();
      if (m_axis_tuser != want.kind || m_axis_tdata != want.chr ||
          m_axis_tlast != want.last) begin
        if (fail_count_o < 10)
          $display("mismatch: exp kind %0d char %h last %b, got kind %0d char %h last %b",
                   want.kind, want.chr, want.last, m_axis_tuser, m_axis_tdata,
                   m_axis_tlast);
        fail_count_o++;
      end
    end
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      = LEX_PLAIN;
      word_open_q = 1'b0;
      expected_events.delete();
      pending_o   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_beat(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        check_event();
      pending_o = expected_events.size();
    end
  end

endmodule

>>> dv/shell_word_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// shell_word_tokenizer_tb
// Feeds command lines into the tokenizer, first a few hand-made lines that hit
// quoting, escapes, comments and line-end corner cases, then random lines made
// of words, quotes, escapes, pipes and noise, with random gaps and stalls.
// ----------------------------------------------------------------------------
module shell_word_tokenizer_tb;
  import swt_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] byte_value
  logic       s_axis_tuser;   // [0] byte_valid
  logic       s_axis_tlast;   // end_of_line
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] char_value
  logic [2:0] m_axis_tuser;   // [2:0] event_kind
  logic       m_axis_tlast;   // last_of_run
  int         fail_count;
  int         pending;

  logic [7:0] line_q[$];
  int         items_sent = 0;
  bit         tx_no_gaps = 1'b0;
  bit         rx_no_stalls = 1'b0;

  shell_word_tokenizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  swt_event_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // one input beat: random gap, then hold until accepted
  task automatic send_beat(input logic [7:0] b, input logic valid, input logic eol);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_no_gaps = ~tx_no_gaps;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= valid;
    s_axis_tlast  <= eol;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // append one byte to the line being built
  function automatic void put_byte(logic [7:0] b);
    line_q.insert(line_q.size(), b);
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // send the collected line, ending on its last byte or on a bare line end
  task automatic send_line(input bit bare_end, input bit with_idle);
    for (int i = 0; i < line_q.size(); i++) begin
      if (with_idle && $urandom_range(0, 19) == 0)
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(line_q[i], 1'b1, !bare_end && (i == line_q.size() - 1));
    end
    if (bare_end || line_q.size() == 0)
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    line_q.delete();
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] word_byte();
    return ($urandom_range(0, 3) == 0) ? any_byte() : 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  // random line built from shell-like pieces
  task automatic build_random_line();
    int pieces;
    pieces = $urandom_range(1, 8);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 4)) put_byte(word_byte());
        end
        3: begin
          put_byte($urandom_range(0, 1) ? ChSpace : 8'($urandom_range(9, 13)));
        end
        4: begin
          put_byte(ChPipe);
        end
        5: begin
          put_byte(ChSquote);
          repeat ($urandom_range(0, 3)) put_byte(any_byte());
          if ($urandom_range(0, 9) != 0) put_byte(ChSquote);
        end
        6: begin
          put_byte(ChDquote);
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 3) == 0) put_byte(ChBslash);
            put_byte(word_byte());
          end
          if ($urandom_range(0, 9) != 0) put_byte(ChDquote);
        end
        7: begin
          put_byte(ChBslash);
          case ($urandom_range(0, 5))
            0: put_byte(ChSpace);
            1: put_byte(ChSquote);
            2: put_byte(ChDquote);
            3: put_byte(ChPipe);
            4: put_byte(ChBslash);
            default: put_byte(word_byte());
          endcase
        end
        8: begin
          put_byte(ChHash);
          repeat ($urandom_range(0, 3)) put_byte(word_byte());
        end
        default: begin
          repeat ($urandom_range(1, 3)) put_byte(any_byte());
        end
      endcase
    end
  endtask

  // output side: random stall before each event beat
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 39) == 0) rx_no_stalls = ~rx_no_stalls;
      stall = rx_no_stalls ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // reset, stimulus and verdict
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty quote pairs, then a hash with no word open starts a comment
    add_text("''\"\"#x");
    send_line(1'b1, 1'b0);
    // ordinary byte after a backslash, pipe, backslash left at line end
    add_text("\\q|\\");
    send_line(1'b0, 1'b0);
    // extreme bytes, an idle beat, tab, backslash pending in double quotes
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(ChTab, 1'b1, 1'b0);
    send_beat(ChDquote, 1'b1, 1'b0);
    send_beat(ChBslash, 1'b1, 1'b1);
    // hash inside a word, then an unclosed single quote
    add_text("a#'x");
    send_line(1'b0, 1'b0);
    // escaped quote inside double quotes, escaped pipe in plain text
    add_text("\"\\\"\"\\|");
    send_line(1'b0, 1'b0);

    // random lines
    while (items_sent < 268) begin
      build_random_line();
      send_line($urandom_range(0, 3) == 0, 1'b1);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS shell_word_tokenizer");
    end else begin
      $display("FAIL shell_word_tokenizer");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL shell_word_tokenizer");
    $finish;
  end

endmodule

>>> files.f
rtl/core/swt_pkg.sv
rtl/core/swt_front.sv
rtl/core/swt_fifo.sv
rtl/core/swt_back.sv
rtl/core/shell_word_tokenizer.sv
dv/swt_event_checker.sv
dv/shell_word_tokenizer_tb.sv
